/* rtl/serial_frame_parser_crc16_defines.svh */
`ifndef SERIAL_FRAME_PARSER_CRC16_DEFINES_SVH
`define SERIAL_FRAME_PARSER_CRC16_DEFINES_SVH

// Property that must hold in the same cycle, ignored while reset is high.
`define SFP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the following cycle, ignored while reset is high.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Property on the cycle after reset, so reset itself is not masked.
`define SFP_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sfp_pkg.sv */
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int MAX_PAYLOAD_BYTES = 256;

   localparam logic [7:0] SofA = 8'hAA;
   localparam logic [7:0] SofB = 8'h55;
   localparam logic [7:0] EomA = 8'h66;
   localparam logic [7:0] EomB = 8'hBB;

   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;

   localparam int CsrAddrWidth = 3;
   localparam logic CsrSelVersion = 1'b0;
   localparam logic CsrSelLimit   = 1'b1;

   localparam logic [7:0] VersionReset = 8'd1;
   localparam logic [8:0] LimitReset   = 9'd256;

   typedef enum logic [2:0] {
      StMore = 3'd0,
      StOk   = 3'd1,
      StEVer = 3'd2,
      StELen = 3'd3,
      StEEnd = 3'd4,
      StECrc = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] expected_version;
      logic [8:0] payload_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] status;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] message_id;
      logic [7:0] frame_flags;
      logic [7:0] sequence_res;
      logic [8:0] payload_length;
   } result_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/sfp_csr.sv */
`timescale 1ns / 1ps

module sfp_csr
   import sfp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   logic [7:0] version_ff, version_in;
   logic [8:0] limit_ff, limit_in;
   logic       wr_en;
   logic       sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign sel    = paddr[2];

   always_comb begin
      version_in = version_ff;
      limit_in   = limit_ff;
      prdata     = '0;
      unique case (sel)
         CsrSelVersion: begin
            prdata = {24'd0, version_ff};
            if (wr_en) begin
               version_in = pwdata[7:0];
            end
         end
         CsrSelLimit: begin
            prdata = {23'd0, limit_ff};
            if (wr_en) begin
               limit_in = pwdata[8:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VersionReset;
         limit_ff   <= LimitReset;
      end else begin
         version_ff <= version_in;
         limit_ff   <= limit_in;
      end
   end

   assign cfg.expected_version = version_ff;
   assign cfg.payload_limit    = limit_ff;

endmodule

/* rtl/sfp_core.sv */
`timescale 1ns / 1ps

module sfp_core
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       push_ok,
   output logic       push,
   output result_type result
);

   typedef enum logic [3:0] {
      PhHunt0 = 4'd0,
      PhHunt1 = 4'd1,
      PhVer   = 4'd2,
      PhMsg   = 4'd3,
      PhFlg   = 4'd4,
      PhSeq   = 4'd5,
      PhLenL  = 4'd6,
      PhLenH  = 4'd7,
      PhPay   = 4'd8,
      PhCrcL  = 4'd9,
      PhCrcH  = 4'd10,
      PhEnd0  = 4'd11,
      PhEnd1  = 4'd12
   } phase_type;

   localparam logic [16:0] MaxLimit = 17'(MAX_PAYLOAD_BYTES);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [8:0]  length_ff, length_in;
   logic [8:0]  count_ff, count_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  msg_ff, msg_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  seq_ff, seq_in;

   logic        fire;
   logic        clear;
   logic [7:0]  b;
   logic [15:0] crc_next;
   logic [15:0] full_length;
   logic [16:0] limit;
   logic [8:0]  count_next;

   assign fire      = in_valid_ff & push_ok;
   assign push      = fire;
   assign req_ready = ~in_valid_ff | fire;
   assign b         = in_byte_ff;

   assign crc_next    = crc_add(crc_ff, b);
   assign full_length = {b, length_ff[7:0]};
   assign limit       = ({8'd0, cfg.payload_limit} > MaxLimit) ? MaxLimit
                                                               : {8'd0, cfg.payload_limit};
   assign count_next  = count_ff + 9'd1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid & req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      length_in = length_ff;
      count_in  = count_ff;
      rx_crc_in = rx_crc_ff;
      msg_in    = msg_ff;
      flags_in  = flags_ff;
      seq_in    = seq_ff;
      clear     = 1'b0;
      result    = '0;
      result.status = StMore;
      if (fire) begin
         unique case (phase_ff)
            PhHunt0: begin
               if (b == SofA) begin
                  phase_in = PhHunt1;
               end
            end
            PhHunt1: begin
               if (b == SofB) begin
                  crc_in   = CrcInit;
                  phase_in = PhVer;
               end else if (b != SofA) begin
                  phase_in = PhHunt0;
               end
            end
            PhVer: begin
               if (b != cfg.expected_version) begin
                  clear         = 1'b1;
                  result.status = StEVer;
               end else begin
                  crc_in   = crc_next;
                  phase_in = PhMsg;
               end
            end
            PhMsg: begin
               msg_in   = b;
               crc_in   = crc_next;
               phase_in = PhFlg;
            end
            PhFlg: begin
               flags_in = b;
               crc_in   = crc_next;
               phase_in = PhSeq;
            end
            PhSeq: begin
               seq_in   = b;
               crc_in   = crc_next;
               phase_in = PhLenL;
            end
            PhLenL: begin
               length_in = {1'b0, b};
               crc_in    = crc_next;
               phase_in  = PhLenH;
            end
            PhLenH: begin
               if ({1'b0, full_length} > limit) begin
                  clear         = 1'b1;
                  result.status = StELen;
               end else begin
                  length_in = full_length[8:0];
                  crc_in    = crc_next;
                  count_in  = '0;
                  phase_in  = (full_length == 16'd0) ? PhCrcL : PhPay;
               end
            end
            PhPay: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = b;
               result.payload_index = count_ff[7:0];
               crc_in   = crc_next;
               count_in = count_next;
               if (count_next >= length_ff) begin
                  phase_in = PhCrcL;
               end
            end
            PhCrcL: begin
               rx_crc_in = {8'd0, b};
               phase_in  = PhCrcH;
            end
            PhCrcH: begin
               rx_crc_in = {b, rx_crc_ff[7:0]};
               phase_in  = PhEnd0;
            end
            PhEnd0: begin
               if (b != EomA) begin
                  clear         = 1'b1;
                  result.status = StEEnd;
               end else begin
                  phase_in = PhEnd1;
               end
            end
            PhEnd1: begin
               clear = 1'b1;
               if (b != EomB) begin
                  result.status = StEEnd;
               end else if (crc_ff != rx_crc_ff) begin
                  result.status = StECrc;
               end else begin
                  result.status         = StOk;
                  result.message_id     = msg_ff;
                  result.frame_flags    = flags_ff;
                  result.sequence_res   = seq_ff;
                  result.payload_length = length_ff;
               end
            end
            default: begin
               clear = 1'b1;
            end
         endcase
         if (clear) begin
            phase_in  = PhHunt0;
            crc_in    = CrcInit;
            length_in = '0;
            count_in  = '0;
            rx_crc_in = '0;
            msg_in    = '0;
            flags_in  = '0;
            seq_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_byte_ff  <= '0;
         phase_ff    <= PhHunt0;
         crc_ff      <= CrcInit;
         length_ff   <= '0;
         count_ff    <= '0;
         rx_crc_ff   <= '0;
         msg_ff      <= '0;
         flags_ff    <= '0;
         seq_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         in_byte_ff  <= in_byte_in;
         phase_ff    <= phase_in;
         crc_ff      <= crc_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         rx_crc_ff   <= rx_crc_in;
         msg_ff      <= msg_in;
         flags_ff    <= flags_in;
         seq_ff      <= seq_in;
      end
   end

endmodule

/* rtl/sfp_out_queue.sv */
`timescale 1ns / 1ps

module sfp_out_queue
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       push_ok,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   result_type  entry_ff [2];
   logic        head_ff, head_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;
   logic        tail;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid & rsp_ready;
   assign push_ok   = (count_ff != 2'd2) | pop;
   assign tail      = head_ff ^ count_ff[0];
   assign rsp_data  = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail] <= push_data;
      end
   end

endmodule

/* rtl/serial_frame_parser_crc16.sv */
`timescale 1ns / 1ps

// Byte-stream deframer for AA 55 | VER MSG FLAGS SEQ LEN(le) | PAYLOAD | CRC(le) | 66 BB
// frames, checked with CRC-16/CCITT-FALSE from the version byte to the last payload byte.
// Each received word on the req_ channel gives exactly one word on the rsp_ channel: a
// status (need more, ok, or a version, length, end marker or CRC error), the payload byte
// and its index when the byte is payload, and the header fields with status ok.
// Both channels use valid and ready; the APB port holds the expected version and the
// payload length limit, and must be written only while the parser is idle; the block
// itself does not enforce this. An accepted word is registered in the input register,
// parsed combinationally and, once the result queue has room, pushed into that queue,
// which offers its result. One word is accepted every cycle while the queue can take a
// result; the per-word CRC byte update and the phase transition sit between the input
// register and a two-entry result queue.
// When the receiver stalls, the queue holds up to two results and the input register a
// third word before req_ready falls; nothing is dropped.
// Reset clears the parser to hunting for the first start byte, empties the queue and
// restores the registers to version 1 and a limit of 256 bytes.

module serial_frame_parser_crc16
   import sfp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic                    rsp_payload_valid,
   output logic [7:0]              rsp_payload_byte,
   output logic [7:0]              rsp_payload_index,
   output logic [7:0]              rsp_message_id,
   output logic [7:0]              rsp_frame_flags,
   output logic [7:0]              rsp_sequence_res,
   output logic [8:0]              rsp_payload_length,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   cfg_type    cfg;
   logic       push;
   logic       push_ok;
   result_type push_data;
   result_type rsp_data;

   sfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_ok     (push_ok),
      .push        (push),
      .result      (push_data)
   );

   sfp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .push_ok   (push_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_payload_valid  = rsp_data.payload_valid;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_payload_index  = rsp_data.payload_index;
   assign rsp_message_id     = rsp_data.message_id;
   assign rsp_frame_flags    = rsp_data.frame_flags;
   assign rsp_sequence_res   = rsp_data.sequence_res;
   assign rsp_payload_length = rsp_data.payload_length;

endmodule

/* rtl/sfp_checker.sv */
`timescale 1ns / 1ps
`include "serial_frame_parser_crc16_defines.svh"

module sfp_checker
   import sfp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_payload_index,
   input logic [7:0] rsp_message_id,
   input logic [7:0] rsp_frame_flags,
   input logic [7:0] rsp_sequence_res,
   input logic [8:0] rsp_payload_length
);

   `SFP_ASSERT_AFTER_RESET(a_empty_after_reset, !rsp_valid, "result offered after reset")

   `SFP_ASSERT_SAME(a_payload_only_need_more, rsp_valid && rsp_payload_valid, rsp_status == StMore, "payload word with a final status")

   `SFP_ASSERT_SAME(a_payload_fields_clear, rsp_valid && !rsp_payload_valid, rsp_payload_byte == 8'd0 && rsp_payload_index == 8'd0, "payload fields set on a non-payload word")

   `SFP_ASSERT_SAME(a_header_only_on_ok, rsp_valid && rsp_status != StOk, rsp_message_id == 8'd0 && rsp_frame_flags == 8'd0 && rsp_sequence_res == 8'd0 && rsp_payload_length == 9'd0, "header fields set without status ok")

   `SFP_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "stalled result changed")

endmodule

bind serial_frame_parser_crc16 sfp_checker u_checker (.*);
